// File: hw/rtl/cpo_pkg.sv
// Shared types and constants for the convex polygon overlap block.
`default_nettype none
package cpo_pkg;
  localparam int CoordW = 16;
  localparam int CrossW = 36;

  localparam logic [2:0] CauseNone   = 3'd0;
  localparam logic [2:0] CauseC2In1  = 3'd1;
  localparam logic [2:0] CauseC1In2  = 3'd2;
  localparam logic [2:0] CauseV2In1  = 3'd3;
  localparam logic [2:0] CauseV1In2  = 3'd4;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusEmpty    = 2'd1;
  localparam logic [1:0] StatusOverflow = 2'd2;

  typedef struct packed {
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } vertex_t;

  // Test point at doubled scale.
  typedef struct packed {
    logic signed [CoordW:0] y;
    logic signed [CoordW:0] x;
  } point_t;

  typedef struct packed {
    logic   valid;
    logic   outside;
    point_t pt;
  } probe_t;
endpackage
`default_nettype wire

// File: hw/rtl/cpo_if.sv
// Valid/ready channel interfaces for vertex input and overlap result.
`default_nettype none
interface cpo_in_if;
  logic                valid;
  logic                ready;
  logic                req_type;
  logic signed [15:0]  vertex_x;
  logic signed [15:0]  vertex_y;
  logic                last_vertex;
  modport source (output valid, req_type, vertex_x, vertex_y, last_vertex, input ready);
  modport sink   (input valid, req_type, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface cpo_out_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [2:0] hit_cause;
  logic [1:0] status;
  modport source (output valid, hit, hit_cause, status, input ready);
  modport sink   (input valid, hit, hit_cause, status, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/cpo_cell.sv
// One edge cell: holds one polygon edge and tests the passing point against it.
`default_nettype none
module cpo_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire cpo_pkg::vertex_t va,
  input  wire cpo_pkg::vertex_t vb,
  input  wire logic            en,
  input  wire cpo_pkg::probe_t pin,
  output cpo_pkg::probe_t      pout
);
  import cpo_pkg::*;

  logic signed [CoordW:0] ex2, ey2;  // doubled edge start
  logic signed [CoordW:0] lx, ly;    // edge vector
  logic signed [CoordW+1:0] ax, ay;
  logic signed [CrossW-1:0] cr;

  always_ff @(posedge clk) begin
    if (load) begin
      ex2 <= {va.x, 1'b0};
      ey2 <= {va.y, 1'b0};
      lx  <= {vb.x[CoordW-1], vb.x} - {va.x[CoordW-1], va.x};
      ly  <= {vb.y[CoordW-1], vb.y} - {va.y[CoordW-1], va.y};
    end
  end

  always_comb begin
    ax = {pin.pt.x[CoordW], pin.pt.x} - {ex2[CoordW], ex2};
    ay = {pin.pt.y[CoordW], pin.pt.y} - {ey2[CoordW], ey2};
    cr = CrossW'(ax * ly) - CrossW'(ay * lx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pout.valid <= 1'b0;
    end else if (en) begin
      pout.valid <= pin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pout.pt      <= pin.pt;
      pout.outside <= pin.outside | (pin.valid & (cr > 0));
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/convex_polygon_overlap_top.sv
// Top level of the convex polygon overlap block.
// Usage: vertices arrive on channel in (req_type picks polygon, x/y signed
// Q8.8). A vertex for a full polygon is dropped and flags overflow. A beat
// with last_vertex set stores its vertex and then evaluates the pair; that
// is the only beat producing a result on channel out (hit, hit_cause,
// status). Loading accepts a vertex on every handshake while in the load
// state. Evaluation runs two passes; each loads the edges of one polygon
// into a row of MAX_VERTICES edge cells, then streams the box centre and
// each vertex of the other polygon through the row, one point per cycle;
// a point's verdict leaves the row after passing all MAX_VERTICES cell
// registers. An empty or overflowed pair answers without running passes.
// Input is held off while evaluating and while a result waits; a stalled
// receiver keeps the result register full. Reset clears counts, boxes and
// the flags; vertex stores are not cleared.
`default_nettype none
module convex_polygon_overlap_top #(
  parameter int MAX_VERTICES = 16
) (
  input wire logic clk,
  input wire logic rst,
  cpo_in_if.sink   in,
  cpo_out_if.source out
);
  import cpo_pkg::*;

  localparam int N  = MAX_VERTICES;
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam int SW = $clog2(N + 2);

  localparam logic [2:0] SLoad = 3'd0, SEdge = 3'd1, SFeed = 3'd2,
                         SDrain = 3'd3, SOut = 3'd4;
  logic [2:0] state;

  vertex_t mem1 [N];
  vertex_t mem2 [N];
  logic [CW-1:0] cnt1, cnt2;
  logic signed [CoordW-1:0] mnx1, mny1, mxx1, mxy1, mnx2, mny2, mxx2, mxy2;
  logic ovf;

  logic pass;        // 0: edges of first, points from second; 1: reversed
  logic [SW-1:0] feed;   // 0 = centre, k = vertex k-1
  logic [SW-1:0] drain;
  logic [2:0] cause;
  logic [2:0] res_cause;
  logic [1:0] res_status;

  logic acc;
  assign in.ready = (state == SLoad);
  assign acc = in.valid & in.ready;

  logic [CW-1:0] ecnt, pcnt;
  assign ecnt = pass ? cnt2 : cnt1;
  assign pcnt = pass ? cnt1 : cnt2;

  // Edge load: cell j gets V[j], V[j+1 mod n] of the edge polygon.
  logic [N-1:0] cload;
  vertex_t ca [N];
  vertex_t cb [N];
  probe_t chain [N+1];
  always_comb begin
    for (int j = 0; j < N; j++) begin
      ca[j] = pass ? mem2[j] : mem1[j];
      if (CW'(j + 1) < ecnt)
        cb[j] = pass ? mem2[(j + 1) % N] : mem1[(j + 1) % N];
      else
        cb[j] = pass ? mem2[0] : mem1[0];
      cload[j] = (state == SEdge) & (CW'(j) < ecnt);
    end
  end

  // Cells past the count take a zero edge and never flag outside.
  logic bypass_clear;
  assign bypass_clear = (state == SEdge);

  for (genvar g = 0; g < N; g++) begin : g_cell
    vertex_t va_g, vb_g;
    assign va_g = cload[g] ? ca[g] : '0;
    assign vb_g = cload[g] ? cb[g] : '0;
    cpo_cell u_cell (
      .clk(clk), .rst(rst), .load(bypass_clear), .va(va_g), .vb(vb_g),
      .en(1'b1), .pin(chain[g]), .pout(chain[g+1])
    );
  end

  vertex_t pv;
  always_comb begin
    pv = pass ? mem1[IW'(feed - SW'(1))] : mem2[IW'(feed - SW'(1))];
    chain[0].valid = (state == SFeed);
    chain[0].outside = 1'b0;
    if (feed == '0) begin
      chain[0].pt.x = pass ? ({mnx1[CoordW-1], mnx1} + {mxx1[CoordW-1], mxx1})
                           : ({mnx2[CoordW-1], mnx2} + {mxx2[CoordW-1], mxx2});
      chain[0].pt.y = pass ? ({mny1[CoordW-1], mny1} + {mxy1[CoordW-1], mxy1})
                           : ({mny2[CoordW-1], mny2} + {mxy2[CoordW-1], mxy2});
    end else begin
      chain[0].pt.x = {pv.x, 1'b0};
      chain[0].pt.y = {pv.y, 1'b0};
    end
  end

  // Verdicts leave in feed order; track index of each.
  logic [SW-1:0] oidx;
  probe_t o;
  assign o = chain[N];

  // Fold the last verdict into the cause; orders of the four tests are
  // encoded by the cause values themselves.
  function automatic logic [2:0] finalc(input logic [2:0] c, input logic outs,
                                        input logic [SW-1:0] idx, input logic p);
    logic [2:0] r;
    r = c;
    if (!outs && c == CauseNone)
      r = (idx == '0) ? (p ? CauseC1In2 : CauseC2In1) : (p ? CauseV1In2 : CauseV2In1);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (acc) begin
      if (!in.req_type && cnt1 < CW'(N)) mem1[IW'(cnt1)] <= {in.vertex_y, in.vertex_x};
      if (in.req_type && cnt2 < CW'(N)) mem2[IW'(cnt2)] <= {in.vertex_y, in.vertex_x};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (out.valid && out.ready)) begin
      cnt1 <= '0; cnt2 <= '0; ovf <= 1'b0;
      mnx1 <= 16'sh7fff; mny1 <= 16'sh7fff; mxx1 <= -16'sh8000; mxy1 <= -16'sh8000;
      mnx2 <= 16'sh7fff; mny2 <= 16'sh7fff; mxx2 <= -16'sh8000; mxy2 <= -16'sh8000;
      state <= SLoad;
      out.valid <= 1'b0;
    end else begin
      case (state)
        SLoad: if (acc) begin
          if (!in.req_type) begin
            if (cnt1 < CW'(N)) begin
              cnt1 <= cnt1 + CW'(1);
              if (in.vertex_x < mnx1) mnx1 <= in.vertex_x;
              if (in.vertex_x > mxx1) mxx1 <= in.vertex_x;
              if (in.vertex_y < mny1) mny1 <= in.vertex_y;
              if (in.vertex_y > mxy1) mxy1 <= in.vertex_y;
            end else ovf <= 1'b1;
          end else begin
            if (cnt2 < CW'(N)) begin
              cnt2 <= cnt2 + CW'(1);
              if (in.vertex_x < mnx2) mnx2 <= in.vertex_x;
              if (in.vertex_x > mxx2) mxx2 <= in.vertex_x;
              if (in.vertex_y < mny2) mny2 <= in.vertex_y;
              if (in.vertex_y > mxy2) mxy2 <= in.vertex_y;
            end else ovf <= 1'b1;
          end
          if (in.last_vertex) begin
            pass <= 1'b0;
            cause <= CauseNone;
            state <= SEdge;
          end
        end
        SEdge: begin
          if (ovf) begin
            res_status <= StatusOverflow; res_cause <= CauseNone; state <= SOut;
          end else if (cnt1 == '0 || cnt2 == '0) begin
            res_status <= StatusEmpty; res_cause <= CauseNone; state <= SOut;
          end else begin
            // each pass starts with no cause; the first pass's one is kept in c_a
            feed <= '0; drain <= '0; cause <= CauseNone; state <= SFeed;
          end
        end
        SFeed: begin
          if (feed == SW'(pcnt)) state <= SDrain;
          else feed <= feed + SW'(1);
        end
        SDrain: ;
        SOut: if (!out.valid) begin
          out.valid <= 1'b1;
        end
        default: state <= SLoad;
      endcase

      // Collect verdicts; centre has priority over vertices within a pass.
      if ((state == SFeed || state == SDrain) && o.valid) begin
        if (!o.outside && cause == CauseNone) begin
          if (oidx == '0) cause <= pass ? CauseC1In2 : CauseC2In1;
          else cause <= pass ? CauseV1In2 : CauseV2In1;
        end
        drain <= drain + SW'(1);
        if (drain == SW'(pcnt)) begin
          if (pass) begin
            res_status <= StatusOk;
            res_cause <= finalc(cause, o.outside, oidx, pass);
            state <= SOut;
          end else begin
            pass <= 1'b1;
            state <= SEdge;
          end
        end
      end
    end
  end

  assign oidx = drain;

  // Order fix: test 2 (centre one in two) beats test 3 (vertex two in one).
  logic [2:0] c_a, c_b;
  logic [2:0] res_fix;
  always_ff @(posedge clk) begin
    if (state == SEdge && pass && !ovf) c_a <= cause;
  end
  always_comb begin
    c_b = res_cause;
    res_fix = c_b;
    if (c_a == CauseV2In1 && res_cause == CauseC1In2) res_fix = CauseC1In2;
    else if (c_a != CauseNone && res_status == StatusOk) res_fix = c_a;
  end

  assign out.hit = (res_fix != CauseNone) && (res_status == StatusOk);
  assign out.hit_cause = (res_status == StatusOk) ? res_fix : CauseNone;
  assign out.status = res_status;
endmodule
`default_nettype wire

// File: test/convex_polygon_overlap_top_tb.sv
// Self-checking testbench for the convex polygon overlap block.
`timescale 1ns / 1ps
module convex_polygon_overlap_top_tb;
  import cpo_pkg::*;

  localparam int NumVerts = 16;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic       hit;
    logic [2:0] hit_cause;
    logic [1:0] status;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cpo_in_if  vin ();
  cpo_out_if vout ();

  convex_polygon_overlap_top #(.MAX_VERTICES(NumVerts)) u_top (
    .clk(clk),
    .rst(rst),
    .in (vin.sink),
    .out(vout.source)
  );

  always #2 clk = ~clk;

  // predictor state
  logic signed [15:0] poly_x [2][NumVerts];
  logic signed [15:0] poly_y [2][NumVerts];
  int                 poly_n [2];
  int                 box_lo_x [2], box_hi_x [2], box_lo_y [2], box_hi_y [2];
  bit                 spill;

  verdict_t verdicts_due [$];
  int       n_bad;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       quiet_cycles;
  bit       timed_out;

  function automatic void clear_pair();
    for (int p = 0; p < 2; p++) begin
      poly_n[p] = 0;
      box_lo_x[p] = 32767;  box_lo_y[p] = 32767;
      box_hi_x[p] = -32768; box_hi_y[p] = -32768;
    end
    spill = 1'b0;
  endfunction

  // point given at doubled scale
  function automatic bit point_within(int p, longint px2, longint py2);
    longint ax, ay, lx, ly;
    int k;
    for (int j = 0; j < poly_n[p]; j++) begin
      k = (j + 1 < poly_n[p]) ? j + 1 : 0;
      ax = px2 - 2 * longint'(poly_x[p][j]);
      ay = py2 - 2 * longint'(poly_y[p][j]);
      lx = longint'(poly_x[p][k]) - longint'(poly_x[p][j]);
      ly = longint'(poly_y[p][k]) - longint'(poly_y[p][j]);
      if (ax * ly - ay * lx > 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit corner_within(int src, int dst);
    for (int i = 0; i < poly_n[src]; i++)
      if (point_within(dst, 2 * longint'(poly_x[src][i]), 2 * longint'(poly_y[src][i])))
        return 1'b1;
    return 1'b0;
  endfunction

  function automatic void predict_overlap(bit sel, logic signed [15:0] x,
                                          logic signed [15:0] y, bit last);
    verdict_t v;
    int p;
    p = sel;
    if (poly_n[p] < NumVerts) begin
      poly_x[p][poly_n[p]] = x;
      poly_y[p][poly_n[p]] = y;
      poly_n[p]++;
      if (x < box_lo_x[p]) box_lo_x[p] = x;
      if (x > box_hi_x[p]) box_hi_x[p] = x;
      if (y < box_lo_y[p]) box_lo_y[p] = y;
      if (y > box_hi_y[p]) box_hi_y[p] = y;
    end else begin
      spill = 1'b1;
    end
    if (!last) return;
    v = '0;
    if (spill) v.status = StatusOverflow;
    else if (poly_n[0] == 0 || poly_n[1] == 0) v.status = StatusEmpty;
    else begin
      v.status = StatusOk;
      if (point_within(0, box_lo_x[1] + box_hi_x[1], box_lo_y[1] + box_hi_y[1]))
        v.hit_cause = CauseC2In1;
      else if (point_within(1, box_lo_x[0] + box_hi_x[0], box_lo_y[0] + box_hi_y[0]))
        v.hit_cause = CauseC1In2;
      else if (corner_within(1, 0)) v.hit_cause = CauseV2In1;
      else if (corner_within(0, 1)) v.hit_cause = CauseV1In2;
      else v.hit_cause = CauseNone;
      v.hit = (v.hit_cause != CauseNone);
    end
    verdicts_due.push_back(v);
    clear_pair();
  endfunction

  initial begin
    vin.valid = 1'b0;
    vin.req_type = 1'b0;
    vin.vertex_x = '0;
    vin.vertex_y = '0;
    vin.last_vertex = 1'b0;
    vout.ready = 1'b0;
  end

  task automatic send_vertex(bit sel, logic signed [15:0] x, logic signed [15:0] y,
                             bit last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      vin.valid <= 1'b0;
      @(posedge clk);
    end
    vin.valid       <= 1'b1;
    vin.req_type    <= sel;
    vin.vertex_x    <= x;
    vin.vertex_y    <= y;
    vin.last_vertex <= last;
    @(posedge clk);
    while (!vin.ready) @(posedge clk);
    predict_overlap(sel, x, y, last);
  endtask

  task automatic pause_sender();
    vin.valid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver, checker and watchdog
  always @(posedge clk) begin
    verdict_t got, want;
    if (rst) begin
      vout.ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (vout.valid && vout.ready) begin
        got = '{vout.hit, vout.hit_cause, vout.status};
        if (verdicts_due.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected beat: %p", got);
        end else begin
          want = verdicts_due.pop_front();
          if (got !== want) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch: expected hit/cause/status %0d/%0d/%0d, got %0d/%0d/%0d",
                       want.hit, want.hit_cause, want.status,
                       got.hit, got.hit_cause, got.status);
          end
        end
      end
      vout.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      if ((vin.valid && vin.ready) || (vout.valid && vout.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit && !timed_out) begin
        timed_out = 1'b1;
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic logic signed [15:0] rand_coord(int span);
    if (span == 0) return 16'($urandom);
    return 16'($signed($urandom_range(2 * span)) - span);
  endfunction

  // convex polygon: points on a rough circle, in order
  task automatic send_shape(bit sel, int n, int cx, int cy, int r, bit close_it);
    bit flip;
    real a;
    flip = $urandom_range(1);
    for (int i = 0; i < n; i++) begin
      a = 6.2831853 * i / n;
      if (flip) a = -a;
      send_vertex(sel, 16'(cx + int'(r * $cos(a))), 16'(cy + int'(r * $sin(a))),
                  close_it && i == n - 1);
    end
  endtask

  task automatic test_directed();
    // square and triangle overlapping
    send_vertex(0, -100, -100, 0); send_vertex(0, 100, -100, 0);
    send_vertex(0, 100, 100, 0);   send_vertex(0, -100, 100, 0);
    send_vertex(1, -50, -50, 0);   send_vertex(1, 50, -50, 0);
    send_vertex(1, 50, 50, 1);
    // extremes, disjoint
    send_vertex(0, -32768, -32768, 0); send_vertex(0, -32767, -32768, 0);
    send_vertex(1, 32767, 32767, 0);   send_vertex(1, 32766, 32767, 1);
    // empty second polygon, closed with a first-polygon beat
    send_vertex(0, 7, 7, 1);
    // single vertices each
    send_vertex(0, 16'h5555, 16'shaaaa, 0); send_vertex(1, 16'shaaaa, 16'h5555, 1);
    // overflow
    for (int i = 0; i < NumVerts + 1; i++) send_vertex(1, 16'(i), 16'(i * 3), 0);
    send_vertex(0, 0, 0, 1);
  endtask

  task automatic test_random(int pairs);
    int n0, n1, span, r;
    for (int k = 0; k < pairs; k++) begin
      case ($urandom_range(9))
        0: begin  // noise
          n0 = $urandom_range(4);
          for (int i = 0; i < n0; i++)
            send_vertex($urandom_range(1), rand_coord(0), rand_coord(0), 0);
          send_vertex($urandom_range(1), rand_coord(0), rand_coord(0), 1);
        end
        1: begin  // overflow or near-full
          n0 = $urandom_range(NumVerts - 2, NumVerts + 1);
          send_shape(0, n0, 0, 0, 3000, 0);
          send_shape(1, $urandom_range(1, 4), 100, 100, 2000, 1);
        end
        default: begin
          n0 = $urandom_range(1, 6);
          n1 = $urandom_range(1, 6);
          span = ($urandom_range(3) == 0) ? 12000 : 3000;
          r = $urandom_range(10, 8000);
          send_shape(0, n0, rand_coord(span), rand_coord(span), r, 0);
          send_shape(1, n1, rand_coord(span), rand_coord(span),
                     $urandom_range(10, 8000), 1);
        end
      endcase
    end
  endtask

  task automatic drain();
    vin.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic run_phase(int idle, int stall, int pairs);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    test_random(pairs);
  endtask

  initial begin
    n_bad = 0;
    timed_out = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    clear_pair();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    pause_sender();
    run_phase(0, 0, 50);
    run_phase(85, 0, 45);
    run_phase(0, 85, 45);
    run_phase(33, 33, 45);
    run_phase(0, 0, 12);
    drain();
    if (n_bad == 0 && verdicts_due.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

// File: sim.f
hw/rtl/cpo_pkg.sv
hw/rtl/cpo_if.sv
hw/rtl/cpo_cell.sv
hw/rtl/convex_polygon_overlap_top.sv
test/convex_polygon_overlap_top_tb.sv
